/* rtl/gapped_tetramer_pair_histogram_top_defines.svh */
// Assertion macros for the gapped tetramer pair histogram
`ifndef GAPPED_TETRAMER_PAIR_HISTOGRAM_TOP_DEFINES_SVH
`define GAPPED_TETRAMER_PAIR_HISTOGRAM_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GTPH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GTPH_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GTPH_ASSERT(label, clk, rst, prop, msg)
`define GTPH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/gtph_pkg.sv */
// Package with shared types and constants for the gapped tetramer pair histogram
package gtph_pkg;
   localparam int GapMaxDefault = 64;
   localparam int Lead = 4;
   localparam logic [1:0] OP_SYMBOL = 2'd0;
   localparam logic [1:0] OP_END    = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] CSR_A = 2'd0;
   localparam logic [1:0] CSR_C = 2'd1;
   localparam logic [1:0] CSR_G = 2'd2;
   localparam logic [1:0] CSR_T = 2'd3;
   localparam logic [1:0] KIND_BLOCK = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic       unclean;
      logic [7:0] tet;
      logic [7:0] first_block;
      logic [7:0] second_block;
      logic [6:0] gap;
   } cmd_type;
endpackage

/* rtl/gtph_if.sv */
// Valid/ready channel interface
interface gtph_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/gtph_front.sv */
// Front end: decodes characters into blocks and hands commands to the queue
`include "gapped_tetramer_pair_histogram_top_defines.svh"
module gtph_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [1:0]         in_op,
   input  logic [7:0]         in_symbol,
   input  logic [7:0]         in_first,
   input  logic [7:0]         in_second,
   input  logic [6:0]         in_gap,
   input  logic [7:0]         codes,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output gtph_pkg::cmd_type  cmd
);
   logic [7:0] tet_ff, tet_in;
   logic [2:0] ncd_ff, ncd_in;
   logic [1:0] seen_ff, seen_in;
   logic [1:0] code;
   logic       is_acgt, accept, emit;

   assign in_ready = cmd_ready;
   assign accept = in_valid && in_ready;

   always_comb begin
      is_acgt = 1'b1;
      code = 2'd0;
      unique case (in_symbol | 8'h20)
         8'h61: code = codes[1:0];
         8'h63: code = codes[3:2];
         8'h67: code = codes[5:4];
         8'h74: code = codes[7:6];
         default: is_acgt = 1'b0;
      endcase
   end

   always_comb begin
      tet_in = tet_ff;
      ncd_in = ncd_ff;
      seen_in = seen_ff;
      emit = 1'b0;
      cmd = '0;
      cmd.first_block = in_first;
      cmd.second_block = in_second;
      cmd.gap = in_gap;
      if (in_op == gtph_pkg::OP_SYMBOL) begin
         tet_in = {tet_ff[5:0], code};
         if (!is_acgt) ncd_in = 3'(gtph_pkg::Lead);
         if (seen_ff != 2'd3) begin
            seen_in = seen_ff + 2'd1;
         end else begin
            emit = 1'b1;
            cmd.kind = gtph_pkg::KIND_BLOCK;
            cmd.tet = tet_in;
            cmd.unclean = (ncd_in != 3'd0);
            if (ncd_in != 3'd0) ncd_in = ncd_in - 3'd1;
         end
      end else if (in_op == gtph_pkg::OP_END) begin
         emit = 1'b1;
         cmd.kind = gtph_pkg::KIND_END;
         tet_in = '0;
         ncd_in = '0;
         seen_in = '0;
      end else if (in_op == gtph_pkg::OP_READ) begin
         emit = 1'b1;
         cmd.kind = gtph_pkg::KIND_READ;
      end
   end

   assign cmd_valid = in_valid && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         tet_ff <= '0;
         ncd_ff <= '0;
         seen_ff <= '0;
      end else if (accept) begin
         tet_ff <= tet_in;
         ncd_ff <= ncd_in;
         seen_ff <= seen_in;
      end
   end

   `GTPH_ASSERT(a_ncd_range, clock, reset, ncd_ff <= 3'd4, "countdown above four")
   `GTPH_ASSERT(a_end_clears, clock, reset,
      accept && in_op == gtph_pkg::OP_END |=> seen_ff == 2'd0 && ncd_ff == 3'd0,
      "end of sequence did not clear")
   `GTPH_ASSERT(a_emit_ready, clock, reset,
      cmd_valid |-> in_valid, "command without input word")
endmodule

/* rtl/gtph_fifo.sv */
// Short command queue between front and back
`include "gapped_tetramer_pair_histogram_top_defines.svh"
module gtph_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  gtph_pkg::cmd_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output gtph_pkg::cmd_type rd_data
);
   gtph_pkg::cmd_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 3'd4;
   assign rd_valid = cnt_ff != 3'd0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, wr} - {2'd0, rd};
      end
   end

   `GTPH_ASSERT(a_cnt_max, clock, reset, cnt_ff <= 3'd4, "queue count overflow")
   `GTPH_ASSERT(a_no_over, clock, reset,
      cnt_ff == 3'd4 && !rd |=> cnt_ff == 3'd4, "queue lost a word")
   `GTPH_ASSERT(a_ptr, clock, reset,
      (wp_ff - rp_ff) == cnt_ff[1:0], "queue pointers inconsistent")
endmodule

/* rtl/gtph_back.sv */
// Back end: block window, pair scan and counter memory with clearing pass
`include "gapped_tetramer_pair_histogram_top_defines.svh"
module gtph_back #(
   parameter int GapMax = gtph_pkg::GapMaxDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  gtph_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [31:0]       out_count
);
   localparam int WinLen = GapMax + gtph_pkg::Lead + 1;
   localparam int Slots = GapMax + 1;
   localparam int SW = $clog2(Slots);
   localparam int WW = $clog2(WinLen + 1);
   localparam int IW = $clog2(WinLen);
   localparam int AW = 16 + SW;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_HEAD = 4'd2, S_HOLD = 4'd3,
                          S_RD = 4'd4, S_READW = 4'd5, S_WR = 4'd6, S_SKIP = 4'd7,
                          S_READ = 4'd8, S_OUT = 4'd9;

   logic [31:0] cnt_mem [2**AW];
   logic [8:0]  win_ff [WinLen];
   logic [3:0]  st_ff;
   logic [AW:0] clr_ff;
   logic [WW-1:0] fill_ff, k_ff, len_ff;
   logic [IW-1:0] head_ff, rp_ff, wpos;
   logic [8:0]  win_q_ff, head_q_ff;
   logic        drop_ff, out_v_ff;
   logic [31:0] out_d_ff, rdata_ff;
   logic [AW-1:0] addr_ff;
   logic        zero_ff;
   logic        take;
   logic [SW-1:0] gk;

   // circular window index: a + b modulo the window length
   function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
      logic [IW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IW+1)'(WinLen)) s = s - (IW+1)'(WinLen);
      return s[IW-1:0];
   endfunction

   assign cmd_ready = (st_ff == S_IDLE) && !out_v_ff && !drop_ff;
   assign take = cmd_valid && cmd_ready;
   assign out_valid = out_v_ff;
   assign out_count = out_d_ff;
   assign gk = SW'(k_ff - WW'(gtph_pkg::Lead));
   assign wpos = wrap_add(head_ff, (fill_ff < WW'(WinLen)) ? fill_ff[IW-1:0]
                                                           : IW'(WinLen - 1));

   always_ff @(posedge clock) begin
      rdata_ff <= cnt_mem[addr_ff];
      if (st_ff == S_CLEAR) cnt_mem[clr_ff[AW-1:0]] <= '0;
      else if (st_ff == S_WR && rdata_ff != 32'hFFFF_FFFF)
         cnt_mem[addr_ff] <= rdata_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      win_q_ff <= win_ff[rp_ff];
      if (take && cmd.kind == gtph_pkg::KIND_BLOCK) win_ff[wpos] <= {cmd.unclean, cmd.tet};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         clr_ff <= '0;
         fill_ff <= '0;
         k_ff <= '0;
         len_ff <= '0;
         head_ff <= '0;
         rp_ff <= '0;
         head_q_ff <= '0;
         drop_ff <= 1'b0;
         out_v_ff <= 1'b0;
         addr_ff <= '0;
         zero_ff <= 1'b0;
      end else begin
         if (out_v_ff && out_ready) out_v_ff <= 1'b0;
         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + (AW+1)'(1);
               if (clr_ff[AW-1:0] == '1) st_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (drop_ff) begin
                  // retire the oldest block
                  drop_ff <= 1'b0;
                  head_ff <= wrap_add(head_ff, IW'(1));
               end else if (take) begin
                  unique case (cmd.kind)
                     gtph_pkg::KIND_BLOCK: begin
                        if (fill_ff < WW'(WinLen)) fill_ff <= fill_ff + WW'(1);
                        if (fill_ff >= WW'(WinLen - 1)) begin
                           len_ff <= WW'(WinLen);
                           k_ff <= WW'(gtph_pkg::Lead);
                           rp_ff <= head_ff;
                           st_ff <= S_HEAD;
                        end
                     end
                     gtph_pkg::KIND_END: begin
                        fill_ff <= '0;
                        if (fill_ff < WW'(WinLen) && fill_ff >= WW'(gtph_pkg::Lead + 1)) begin
                           len_ff <= fill_ff;
                           k_ff <= WW'(gtph_pkg::Lead);
                           rp_ff <= head_ff;
                           st_ff <= S_HEAD;
                        end
                     end
                     gtph_pkg::KIND_READ: begin
                        addr_ff <= AW'({cmd.first_block, cmd.second_block} * Slots)
                                   + AW'(cmd.gap);
                        zero_ff <= cmd.gap > 7'(GapMax);
                        st_ff <= S_READ;
                     end
                     default: ;
                  endcase
               end
            end
            S_HEAD: begin
               rp_ff <= wrap_add(rp_ff, IW'(gtph_pkg::Lead));
               st_ff <= S_HOLD;
            end
            S_HOLD: begin
               head_q_ff <= win_q_ff;
               st_ff <= S_RD;
            end
            S_RD: begin
               // skip unclean head or partner, stop at window end
               if (k_ff >= len_ff || head_q_ff[8]) begin
                  st_ff <= S_IDLE;
                  drop_ff <= (len_ff == WW'(WinLen));
               end else begin
                  addr_ff <= AW'({head_q_ff[7:0], win_q_ff[7:0]} * Slots) + AW'(gk);
                  k_ff <= k_ff + WW'(1);
                  rp_ff <= wrap_add(rp_ff, IW'(1));
                  st_ff <= win_q_ff[8] ? S_SKIP : S_READW;
               end
            end
            S_READW: st_ff <= S_WR;
            S_WR: st_ff <= S_RD;
            S_SKIP: st_ff <= S_RD;
            S_READ: st_ff <= S_OUT;
            S_OUT: begin
               out_d_ff <= zero_ff ? 32'd0 : rdata_ff;
               out_v_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   `GTPH_ASSERT(a_fill, clock, reset, fill_ff <= WW'(WinLen), "window fill overflow")
   `GTPH_ASSERT(a_out_hold, clock, reset,
      out_v_ff && !out_ready |=> out_v_ff, "result dropped")
   `GTPH_ASSERT(a_no_take, clock, reset, st_ff != S_IDLE |-> !cmd_ready,
      "command taken while busy")
endmodule

/* rtl/gapped_tetramer_pair_histogram_top.sv */
// Top level of the gapped tetramer pair histogram
// Usage: after reset a clearing pass sweeps all 256*256*(GAP_MAX+1) counters
// (one per cycle, rounded to a power of two) before the counter engine takes
// any command; the queue may fill meanwhile. A character that completes a full
// window then walks the window on the single counter memory port, with a
// read-wait-write pass per clean pair and a skip step per unclean partner.
// A four-deep queue separates decoding from the counter engine.
module gapped_tetramer_pair_histogram_top #(
   parameter int GAP_MAX = gtph_pkg::GapMaxDefault
) (
   input  logic        clock,
   input  logic        reset,
   gtph_if.sink        req,
   gtph_if.source      rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_wdata
);
   logic [7:0] codes_ff;
   logic q_v, q_r, b_v, b_r;
   gtph_pkg::cmd_type q_d, b_d;

   always_ff @(posedge clock) begin
      if (reset) codes_ff <= 8'b11_10_01_00;
      else if (csr_we) begin
         unique case (csr_index)
            gtph_pkg::CSR_A: codes_ff[1:0] <= csr_wdata;
            gtph_pkg::CSR_C: codes_ff[3:2] <= csr_wdata;
            gtph_pkg::CSR_G: codes_ff[5:4] <= csr_wdata;
            gtph_pkg::CSR_T: codes_ff[7:6] <= csr_wdata;
            default: ;
         endcase
      end
   end

   gtph_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_op(req.data[32:31]), .in_symbol(req.data[30:23]),
      .in_first(req.data[22:15]), .in_second(req.data[14:7]), .in_gap(req.data[6:0]),
      .codes(codes_ff), .cmd_valid(q_v), .cmd_ready(q_r), .cmd(q_d)
   );

   gtph_fifo u_fifo (
      .clock, .reset, .wr_valid(q_v), .wr_ready(q_r), .wr_data(q_d),
      .rd_valid(b_v), .rd_ready(b_r), .rd_data(b_d)
   );

   gtph_back #(.GapMax(GAP_MAX)) u_back (
      .clock, .reset, .cmd_valid(b_v), .cmd_ready(b_r), .cmd(b_d),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_count(rsp.data)
   );
endmodule

/* test/gtph_checker.sv */
// Checker: predicts the histogram counters and compares every read answer
module gtph_checker (
   input  logic       clock,
   input  logic       reset,
   gtph_if            req,
   gtph_if            rsp,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [1:0] csr_wdata,
   output int         errors,
   output int         pending
);
   localparam int WinLen = gtph_pkg::GapMaxDefault + gtph_pkg::Lead + 1;
   localparam int GapSlots = gtph_pkg::GapMaxDefault + 1;

   logic [1:0]  code_map [4];
   logic [7:0]  tet;
   logic [2:0]  n_left;
   logic [1:0]  chars_seen;
   logic [6:0]  fill;
   logic [8:0]  win [WinLen];
   logic [31:0] hist [int];
   logic [31:0] count_q [$];
   int          err_count = 0;

   assign errors = err_count;

   function automatic int hist_key(logic [7:0] a, logic [7:0] b, int g);
      return (int'(a) * 256 + int'(b)) * GapSlots + g;
   endfunction

   task automatic report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic pair_oldest(int len);
      int k;
      int key;
      if (win[0][8]) return;
      for (k = gtph_pkg::Lead; k < len && k < WinLen; k++) begin
         if (!win[k][8]) begin
            key = hist_key(win[0][7:0], win[k][7:0], k - gtph_pkg::Lead);
            if (!hist.exists(key)) hist[key] = 32'd0;
            if (hist[key] != 32'hFFFF_FFFF) hist[key] = hist[key] + 32'd1;
         end
      end
   endtask

   task automatic clear_seq();
      tet = '0;
      n_left = '0;
      chars_seen = '0;
      fill = '0;
      foreach (win[i]) win[i] = '0;
   endtask

   task automatic take_char(logic [7:0] s);
      logic [1:0] code;
      logic [8:0] entry;
      int pos;
      code = 2'd0;
      case (s)
         "A", "a": code = code_map[gtph_pkg::CSR_A];
         "C", "c": code = code_map[gtph_pkg::CSR_C];
         "G", "g": code = code_map[gtph_pkg::CSR_G];
         "T", "t": code = code_map[gtph_pkg::CSR_T];
         default: n_left = 3'(gtph_pkg::Lead);
      endcase
      tet = {tet[5:0], code};
      if (chars_seen < 2'(gtph_pkg::Lead - 1)) begin
         chars_seen++;
         return;
      end
      entry = {1'b0, tet};
      if (n_left != 0) begin
         entry[8] = 1'b1;
         n_left--;
      end
      pos = (fill < WinLen) ? int'(fill) : WinLen - 1;
      win[pos] = entry;
      if (fill < WinLen) fill++;
      if (fill == WinLen) begin
         pair_oldest(WinLen);
         for (int i = 0; i < WinLen - 1; i++) win[i] = win[i + 1];
         win[WinLen - 1] = '0;
      end
   endtask

   always @(posedge clock) begin
      logic [1:0]  op;
      logic [7:0]  sym, fb, sb;
      logic [6:0]  g;
      logic [31:0] want;
      if (reset) begin
         code_map[gtph_pkg::CSR_A] = 2'd0;
         code_map[gtph_pkg::CSR_C] = 2'd1;
         code_map[gtph_pkg::CSR_G] = 2'd2;
         code_map[gtph_pkg::CSR_T] = 2'd3;
         clear_seq();
         hist.delete();
         count_q.delete();
      end else begin
         if (csr_we) code_map[csr_index] = csr_wdata;
         if (req.valid && req.ready) begin
            {op, sym, fb, sb, g} = req.data;
            if (op == gtph_pkg::OP_SYMBOL) begin
               take_char(sym);
            end else if (op == gtph_pkg::OP_END) begin
               if (fill < WinLen && fill >= gtph_pkg::Lead + 1) pair_oldest(int'(fill));
               clear_seq();
            end else if (op == gtph_pkg::OP_READ) begin
               want = 32'd0;
               if (g <= gtph_pkg::GapMaxDefault && hist.exists(hist_key(fb, sb, int'(g))))
                  want = hist[hist_key(fb, sb, int'(g))];
               count_q.push_back(want);
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (count_q.size() == 0) begin
               report($sformatf("unexpected count word %0h", rsp.data));
            end else begin
               want = count_q.pop_front();
               if (rsp.data !== want)
                  report($sformatf("count %0h, predicted %0h", rsp.data, want));
            end
         end
      end
      pending = count_q.size();
   end
endmodule

/* test/tb.sv */
// Testbench top: stimulus, clock, reset, flow control and verdict
module tb;
   localparam int ReqW = 33;
   localparam int HoldOff = 1500;
   localparam int IdleLimit = 40_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [1:0] csr_wdata = '0;
   int errors;
   int pending;
   int idle_cycles = 0;
   logic long_hold = 1'b0;
   int burst_left = 0;

   // codes currently programmed, and recent tetramers as read targets
   logic [1:0] cur_code [4];
   logic [7:0] tb_tet = '0;
   logic [7:0] recent [8];
   int recent_ptr = 0;

   gtph_if #(.W(ReqW)) req ();
   gtph_if #(.W(32)) rsp ();

   gapped_tetramer_pair_histogram_top uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   gtph_checker chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always #6 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      foreach (recent[i]) recent[i] = '0;
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: duty cycle shifts at random, long hold on request
   initial begin
      int duty;
      duty = 100;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) begin
            case ($urandom_range(0, 3))
               0: duty = 100;
               1: duty = 75;
               2: duty = 40;
               default: duty = 10;
            endcase
         end
         rsp.ready <= ($urandom_range(0, 99) < duty);
      end
   end

   task automatic send(logic [1:0] op, logic [7:0] sym, logic [7:0] fb,
                       logic [7:0] sb, logic [6:0] g);
      req.valid <= 1'b1;
      req.data <= {op, sym, fb, sb, g};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         if ($urandom_range(0, 2) != 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic send_char(logic [7:0] s);
      logic [1:0] code;
      code = 2'd0;
      case (s)
         "A", "a": code = cur_code[gtph_pkg::CSR_A];
         "C", "c": code = cur_code[gtph_pkg::CSR_C];
         "G", "g": code = cur_code[gtph_pkg::CSR_G];
         "T", "t": code = cur_code[gtph_pkg::CSR_T];
         default: code = 2'd0;
      endcase
      tb_tet = {tb_tet[5:0], code};
      recent[recent_ptr] = tb_tet;
      recent_ptr = (recent_ptr + 1) % 8;
      send(gtph_pkg::OP_SYMBOL, s, 8'($urandom), 8'($urandom), 7'($urandom));
   endtask

   task automatic send_end();
      tb_tet = '0;
      send(gtph_pkg::OP_END, 8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom));
   endtask

   task automatic send_read();
      logic [7:0] fb, sb;
      logic [6:0] g;
      int pick;
      fb = recent[$urandom_range(0, 7)];
      sb = recent[$urandom_range(0, 7)];
      if ($urandom_range(0, 9) == 0) fb = 8'($urandom);
      if ($urandom_range(0, 9) == 0) sb = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7) g = 7'($urandom_range(0, 12));
      else if (pick < 9) g = 7'($urandom_range(0, 64));
      else g = 7'($urandom_range(0, 127));
      send(gtph_pkg::OP_READ, 8'($urandom), fb, sb, g);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (HoldOff) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cur_code[idx] = val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sequences of a repeated motif keep tetramers recurring so reads hit
   task automatic random_phase(int n_items);
      int sent;
      int seq_len;
      int mlen;
      logic [7:0] motif [6];
      logic [7:0] letters [8];
      logic [7:0] s;
      letters = '{"A", "C", "G", "T", "a", "c", "g", "t"};
      sent = 0;
      while (sent < n_items) begin
         mlen = $urandom_range(1, 6);
         for (int i = 0; i < 6; i++) motif[i] = letters[$urandom_range(0, 7)];
         seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 220)
                                                : $urandom_range(1, 110);
         for (int i = 0; i < seq_len && sent < n_items; i++) begin
            s = motif[i % mlen];
            if ($urandom_range(0, 39) == 0) s = 8'($urandom);
            else if ($urandom_range(0, 59) == 0) s = "N";
            send_char(s);
            sent++;
            if ($urandom_range(0, 11) == 0) begin
               send_read();
               sent++;
            end
            if ($urandom_range(0, 199) == 0)
               send(gtph_pkg::OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                    7'($urandom));
            if (sent == n_items / 2 && $urandom_range(0, 1) == 0) long_hold <= 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            send_end();
            sent++;
         end
         for (int i = 0; i < $urandom_range(0, 4); i++) begin
            send_read();
            sent++;
         end
      end
      send_end();
      drain();
   endtask

   initial begin
      string dna;
      cur_code[gtph_pkg::CSR_A] = 2'd0;
      cur_code[gtph_pkg::CSR_C] = 2'd1;
      cur_code[gtph_pkg::CSR_G] = 2'd2;
      cur_code[gtph_pkg::CSR_T] = 2'd3;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: untouched counter, short window, N handling, odd reads
      send_read();
      dna = "ACGTacgtNAC";
      for (int i = 0; i < dna.len(); i++) send_char(dna[i]);
      send(gtph_pkg::OP_SYMBOL, 8'h00, 8'hFF, 8'hFF, 7'h7F);
      send_char("g");
      send_end();
      send(gtph_pkg::OP_READ, 8'h00, 8'h1B, 8'h1B, 7'd4);
      send(gtph_pkg::OP_READ, 8'h00, 8'h1B, 8'hE4, 7'd0);
      send(gtph_pkg::OP_READ, 8'h00, 8'hFF, 8'hFF, 7'd64);
      send(gtph_pkg::OP_READ, 8'h00, 8'h1B, 8'h1B, 7'd127);
      send(gtph_pkg::OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 7'h7F);
      for (int i = 0; i < 6; i++) send_char("T");
      send_end();
      send(gtph_pkg::OP_READ, 8'h00, 8'hFF, 8'hFF, 7'd0);
      send_char("A");
      send_end();
      drain();

      random_phase(300);
      csr_write(gtph_pkg::CSR_A, 2'd3);
      csr_write(gtph_pkg::CSR_C, 2'd2);
      csr_write(gtph_pkg::CSR_G, 2'd1);
      csr_write(gtph_pkg::CSR_T, 2'd0);
      random_phase(300);
      for (int i = 0; i < 4; i++) csr_write(2'(i), 2'd0);
      random_phase(300);
      for (int i = 0; i < 4; i++) csr_write(2'(i), 2'd3);
      random_phase(300);
      for (int i = 0; i < 4; i++) csr_write(2'(i), 2'($urandom));
      long_hold <= 1'b1;
      random_phase(300);

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* sim.f */
+incdir+rtl
rtl/gtph_pkg.sv
rtl/gtph_if.sv
rtl/gtph_front.sv
rtl/gtph_fifo.sv
rtl/gtph_back.sv
rtl/gapped_tetramer_pair_histogram_top.sv
test/gtph_checker.sv
test/tb.sv
